// ----- rtl/core/pmmh_pkg.sv -----
// shared types and constants of the point motion magnitude histogram
`default_nettype none

package pmmh_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 1;
    localparam int         CFG_DATA_W     = 12;
    localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;
    localparam logic [11:0] RESET_WIDTH   = 12'd640;
    localparam logic [11:0] RESET_HEIGHT  = 12'd480;

    // fixed widths of the arithmetic
    localparam int POS_W   = 20;           // pixel position, 8 fraction bits
    localparam int PROD_W  = 28;           // 16 x 12 scaling product
    localparam int SQ_W    = 40;           // square of a 20 bit difference
    localparam int RAD_W   = 27;           // radicand and square root working width
    localparam int ROOT_W  = 13;           // whole pixel distance
    localparam int COUNT_W = 32;

    // square root unit: two result bits per cycle
    localparam int                ROOT_STEPS = 7;
    localparam int                STEP_W     = 3;
    localparam logic [RAD_W-1:0]  ROOT_BIT0  = RAD_W'(1) << 26;

    // one input item
    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  point_index;
        logic [15:0] x_frac;
        logic [15:0] y_frac;
        logic [5:0]  bin_select;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [31:0] bin_count;
        logic [5:0]  bin_hit;
        logic        counted;
        logic        first_sample;
    } result_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic addr_sel;
        logic clr_start;
        logic scale;
        logic diff;
        logic square;
        logic sum;
        logic root_step;
        logic bin;
        logic mem_rd;
        logic mem_upd;
        logic clr_step;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic act_rec;
        logic act_read;
        logic act_clear;
        logic first;
        logic in_range;
        logic clr_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/pmmh_ctrl.sv -----
// controller state machine sequencing record, read and clear actions
`default_nettype none

module pmmh_ctrl
    import pmmh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output dp_cmd_t         ctl,
    output logic            busy,
    output logic            done
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_SCALE  = 4'd2;
    localparam logic [3:0] ST_DIFF   = 4'd3;
    localparam logic [3:0] ST_SQUARE = 4'd4;
    localparam logic [3:0] ST_SUM    = 4'd5;
    localparam logic [3:0] ST_ROOT   = 4'd6;
    localparam logic [3:0] ST_BIN    = 4'd7;
    localparam logic [3:0] ST_MRD    = 4'd8;
    localparam logic [3:0] ST_MUPD   = 4'd9;
    localparam logic [3:0] ST_CLEAR  = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              clr_ack_reg, clr_ack_next;

    // state, root step count and clear origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            clr_ack_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            clr_ack_reg <= clr_ack_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_ack_next = clr_ack_reg;
        ctl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.act_rec)
                begin
                    state_next = ST_SCALE;
                end
                else if (status.act_read)
                begin
                    ctl.addr_sel = 1'b1;
                    state_next   = ST_MRD;
                end
                else if (status.act_clear)
                begin
                    ctl.clr_start = 1'b1;
                    clr_ack_next  = 1'b1;
                    state_next    = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCALE:
            begin
                ctl.scale  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                ctl.diff   = 1'b1;
                state_next = status.first ? ST_DONE : ST_SQUARE;
            end
            ST_SQUARE:
            begin
                ctl.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ctl.sum    = 1'b1;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                ctl.root_step = 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_BIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_BIN:
            begin
                ctl.bin    = 1'b1;
                state_next = status.in_range ? ST_MRD : ST_DONE;
            end
            ST_MRD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = ST_MUPD;
            end
            ST_MUPD:
            begin
                ctl.mem_upd = 1'b1;
                state_next  = ST_DONE;
            end
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    // a clear action reports, the sweep after reset does not
                    state_next   = clr_ack_reg ? ST_DONE : ST_IDLE;
                    clr_ack_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

`default_nettype wire

// ----- rtl/core/pmmh_datapath.sv -----
// datapath: scaling, distance, square root unit, point state and histogram memory
`default_nettype none

module pmmh_datapath
    import pmmh_pkg::*;
#(
    parameter int NUM_POINTS = 7,
    parameter int NUM_BINS   = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire dp_cmd_t               ctl,
    output dp_status_t                 status,
    output result_t                    result
);

    localparam int DEPTH = NUM_POINTS * NUM_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PT_W  = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

    // configuration
    logic [CFG_DATA_W-1:0] width_reg, height_reg;

    // captured item and working registers
    cmd_t              cmd_reg;
    logic [POS_W-1:0]  nx_reg, ny_reg, dx_reg, dy_reg;
    logic [SQ_W-1:0]   dx2_reg, dy2_reg;
    logic [RAD_W-1:0]  rad_reg, root_reg, bit_reg;
    logic [AW-1:0]     addr_reg, clr_addr_reg;
    logic [COUNT_W-1:0] mem_rd_reg;
    result_t           result_reg;

    // per point state
    logic [POS_W-1:0]      prev_x_reg [NUM_POINTS];
    logic [POS_W-1:0]      prev_y_reg [NUM_POINTS];
    logic [NUM_POINTS-1:0] seen_reg;

    // histogram memory
    logic [COUNT_W-1:0] hist_mem [DEPTH];

    logic [PT_W-1:0]    pt;
    logic               pt_ok, sel_ok;
    logic [PROD_W-1:0]  prod_x, prod_y;
    logic [POS_W-1:0]   px, py;
    logic [SQ_W:0]      sq_sum;
    logic [RAD_W-1:0]   v1, r1, v2, r2, b2;
    logic [AW-1:0]      row_base;
    logic [COUNT_W-1:0] count_inc;
    logic               mem_wr;
    logic [AW-1:0]      mem_wr_addr;
    logic [COUNT_W-1:0] mem_wr_data;

    // decode of the captured item
    assign pt     = PT_W'(cmd_reg.point_index);
    assign pt_ok  = 5'(cmd_reg.point_index) < 5'(NUM_POINTS);
    assign sel_ok = 9'(cmd_reg.bin_select) < 9'(NUM_BINS);

    assign status.act_rec   = (cmd_reg.action == ACT_RECORD) && pt_ok;
    assign status.act_read  = (cmd_reg.action == ACT_READ) && pt_ok && sel_ok;
    assign status.act_clear = (cmd_reg.action == ACT_CLEAR);
    assign status.first     = !seen_reg[pt];
    assign status.in_range  = 14'(root_reg[ROOT_W-1:0]) < 14'(NUM_BINS);
    assign status.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));

    // scaling products and stored position of the point
    assign prod_x = {12'd0, cmd_reg.x_frac} * {16'd0, width_reg};
    assign prod_y = {12'd0, cmd_reg.y_frac} * {16'd0, height_reg};
    assign px     = prev_x_reg[pt];
    assign py     = prev_y_reg[pt];
    assign sq_sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    // two restoring square root steps per cycle
    always_comb
    begin
        v1 = rad_reg;
        r1 = root_reg;
        if (rad_reg >= root_reg + bit_reg)
        begin
            v1 = rad_reg - (root_reg + bit_reg);
            r1 = (root_reg >> 1) + bit_reg;
        end
        else
        begin
            r1 = root_reg >> 1;
        end
        b2 = bit_reg >> 2;
        v2 = v1;
        r2 = r1;
        if (v1 >= r1 + b2)
        begin
            v2 = v1 - (r1 + b2);
            r2 = (r1 >> 1) + b2;
        end
        else
        begin
            r2 = r1 >> 1;
        end
    end

    // memory address of the point's row and saturating count update
    assign row_base  = AW'(cmd_reg.point_index) * AW'(NUM_BINS);
    assign count_inc = (mem_rd_reg == '1) ? mem_rd_reg : mem_rd_reg + 1'b1;

    assign mem_wr      = ctl.clr_step || (ctl.mem_upd && status.act_rec);
    assign mem_wr_addr = ctl.clr_step ? clr_addr_reg : addr_reg;
    assign mem_wr_data = ctl.clr_step ? '0 : count_inc;

    // configuration registers, seen flags and clear sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RESET_WIDTH;
            height_reg   <= RESET_HEIGHT;
            seen_reg     <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IDX_WIDTH:  width_reg  <= cfg_data;
                    CFG_IDX_HEIGHT: height_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (ctl.clr_start)
            begin
                seen_reg <= '0;
            end
            else if (ctl.diff)
            begin
                seen_reg[pt] <= 1'b1;
            end
            if (ctl.clr_step)
            begin
                clr_addr_reg <= status.clr_last ? '0 : clr_addr_reg + 1'b1;
            end
        end
    end

    // stored positions
    always_ff @(posedge clk)
    begin
        if (ctl.clr_start)
        begin
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                prev_x_reg[i] <= '0;
                prev_y_reg[i] <= '0;
            end
        end
        else if (ctl.diff)
        begin
            prev_x_reg[pt] <= nx_reg;
            prev_y_reg[pt] <= ny_reg;
        end
    end

    // working registers and result
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            result_reg <= '0;
        end
        if (ctl.scale)
        begin
            nx_reg <= prod_x[PROD_W-1:8];
            ny_reg <= prod_y[PROD_W-1:8];
        end
        if (ctl.diff)
        begin
            dx_reg <= (nx_reg >= px) ? nx_reg - px : px - nx_reg;
            dy_reg <= (ny_reg >= py) ? ny_reg - py : py - ny_reg;
            if (status.first)
            begin
                result_reg.first_sample <= 1'b1;
            end
        end
        if (ctl.square)
        begin
            dx2_reg <= dx_reg * dx_reg;
            dy2_reg <= dy_reg * dy_reg;
        end
        // whole pixels: root of the sum with its 16 fraction bits dropped
        if (ctl.sum)
        begin
            rad_reg  <= RAD_W'(sq_sum[SQ_W:16]);
            root_reg <= '0;
            bit_reg  <= ROOT_BIT0;
        end
        if (ctl.root_step)
        begin
            rad_reg  <= v2;
            root_reg <= r2;
            bit_reg  <= b2 >> 2;
        end
        if (ctl.bin)
        begin
            result_reg.bin_hit <= (root_reg > RAD_W'(63)) ? 6'd63 : root_reg[5:0];
            addr_reg           <= row_base + AW'(root_reg);
        end
        if (ctl.addr_sel)
        begin
            addr_reg <= row_base + AW'(cmd_reg.bin_select);
        end
        if (ctl.mem_upd)
        begin
            if (status.act_rec)
            begin
                result_reg.bin_count <= count_inc;
                result_reg.counted   <= 1'b1;
            end
            else
            begin
                result_reg.bin_count <= mem_rd_reg;
            end
        end
    end

    // histogram memory write port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            hist_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // histogram memory read port
    always_ff @(posedge clk)
    begin
        if (ctl.mem_rd)
        begin
            mem_rd_reg <= hist_mem[addr_reg];
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/core/point_motion_magnitude_histogram_top.sv -----
// top level of the point motion magnitude histogram
// record item: scale, difference, square, sum, square root (two bits a cycle), bin, then the
//   memory read-modify-write and the done strobe; a new item is taken when busy is low again
// record of a first sample ends after the difference; beyond the last bin: after binning;
// read item: after the memory read; clear item: after a NUM_POINTS*NUM_BINS memory sweep;
// ignored or out of range item: after decode; after reset busy stays high for a 448 word sweep
`default_nettype none

module point_motion_magnitude_histogram_top
    import pmmh_pkg::*;
#(
    parameter int NUM_POINTS = 7,
    parameter int NUM_BINS   = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire cmd_t                  cmd,
    output logic                       done,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    ctl;
    dp_status_t status;

    // registers are always writable
    assign cfg_ready = 1'b1;

    pmmh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctl    (ctl),
        .busy   (busy),
        .done   (done)
    );

    pmmh_datapath #(
        .NUM_POINTS (NUM_POINTS),
        .NUM_BINS   (NUM_BINS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .status    (status),
        .result    (result)
    );

    // an accepted item keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // the block is free again right after a result
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    // a first sample never counts
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.counted && result.first_sample))
        else $error("first sample reported as counted");

    // a counted sample leaves a non-zero bin
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.counted) |-> (result.bin_count != 32'd0))
        else $error("counted sample with zero bin count");

endmodule

`default_nettype wire
